### design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Holds the fixed-point widths, the register map, the microcode word layout
// and the microcode program that sequences one filter update.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    // Sample and estimate width, signed Q16.16.
    localparam int SAMPLE_WIDTH = 32;
    // Covariance and noise registers, unsigned Q16.16.
    localparam int COV_W = 32;
    // Gain, unsigned Q1.16 with 65536 meaning 1.0.
    localparam int GAIN_W = 17;
    localparam int FRAC_W = 16;

    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [COV_W-1:0]  COV_INIT = 32'd655360;
    localparam logic [COV_W-1:0]  MEAS_NOISE_RESET = 32'd65536;
    localparam logic [COV_W-1:0]  PROC_NOISE_RESET = 32'd655;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MEAS_NOISE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROC_NOISE = 2'd1;

    // Shared multiplier: an 18-bit signed operand (zero-extended gain) times
    // a signed operand wide enough for the innovation and for the covariance.
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = (SAMPLE_WIDTH + 1 > COV_W + 1) ? SAMPLE_WIDTH + 1 : COV_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Divider: one quotient bit per cycle, 17 bits of gain.
    localparam int DEN_W      = COV_W + 1;
    localparam int REM_W      = COV_W + 2;
    localparam int DIV_STEPS  = GAIN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Program counter and named program addresses.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
    localparam logic [PC_W-1:0] PC_ADDQ  = 4'd1;
    localparam logic [PC_W-1:0] PC_DEN   = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd3;
    localparam logic [PC_W-1:0] PC_MULI  = 4'd4;
    localparam logic [PC_W-1:0] PC_UPDE  = 4'd5;
    localparam logic [PC_W-1:0] PC_MULC  = 4'd6;
    localparam logic [PC_W-1:0] PC_UPDC  = 4'd7;
    localparam logic [PC_W-1:0] PC_FIRST = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;
    localparam logic [PC_W-1:0] PC_LAST  = PC_EMIT;

    // Datapath operation of one microcode step.
    typedef enum logic [3:0] {
        OP_LOAD      = 4'd0,  // capture the input word
        OP_ADD_Q     = 4'd1,  // P = sat(P + Q)
        OP_DEN       = 4'd2,  // den = P + R, set up the divider
        OP_DIV       = 4'd3,  // one quotient bit
        OP_MUL_INNOV = 4'd4,  // product = K * (sample - est)
        OP_UPD_EST   = 4'd5,  // est += floor(product / 2^16)
        OP_MUL_COV   = 4'd6,  // product = (1 - K) * P
        OP_UPD_COV   = 4'd7,  // P = floor(product / 2^16)
        OP_FIRST     = 4'd8,  // est = sample, P = 10.0, K = 0
        OP_EMIT      = 4'd9   // hand the result to the output register
    } skf_op_t;

    // Sequencing of one microcode step.
    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,  // fall through
        JC_GOTO     = 3'd1,  // unconditional jump
        JC_IF_FIRST = 3'd2,  // jump when the word starts a new sequence
        JC_DIV_LOOP = 3'd3,  // jump while quotient bits remain
        JC_WAIT_IN  = 3'd4,  // hold until an input word is accepted
        JC_WAIT_OUT = 3'd5   // hold until the output register is free, then jump
    } skf_jump_t;

    typedef struct packed {
        skf_op_t         op;
        skf_jump_t       jump;
        logic [PC_W-1:0] target;
    } skf_ucode_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic first;
        logic div_last;
    } skf_status_t;

    // Microcode program.
    function automatic skf_ucode_t skf_ucode(input logic [PC_W-1:0] pc);
        skf_ucode_t w;
        w = '{op: OP_LOAD, jump: JC_GOTO, target: PC_LOAD};
        unique case (pc)
            PC_LOAD:  w = '{op: OP_LOAD,      jump: JC_WAIT_IN,  target: PC_LOAD};
            PC_ADDQ:  w = '{op: OP_ADD_Q,     jump: JC_IF_FIRST, target: PC_FIRST};
            PC_DEN:   w = '{op: OP_DEN,       jump: JC_NEXT,     target: PC_LOAD};
            PC_DIV:   w = '{op: OP_DIV,       jump: JC_DIV_LOOP, target: PC_DIV};
            PC_MULI:  w = '{op: OP_MUL_INNOV, jump: JC_NEXT,     target: PC_LOAD};
            PC_UPDE:  w = '{op: OP_UPD_EST,   jump: JC_NEXT,     target: PC_LOAD};
            PC_MULC:  w = '{op: OP_MUL_COV,   jump: JC_NEXT,     target: PC_LOAD};
            PC_UPDC:  w = '{op: OP_UPD_COV,   jump: JC_GOTO,     target: PC_EMIT};
            PC_FIRST: w = '{op: OP_FIRST,     jump: JC_NEXT,     target: PC_LOAD};
            PC_EMIT:  w = '{op: OP_EMIT,      jump: JC_WAIT_OUT, target: PC_LOAD};
            default:  w = '{op: OP_LOAD,      jump: JC_GOTO,     target: PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### design/skf_in_if.sv
// ----------------------------------------------------------------------------
// skf_in_if: sample channel
// Valid/ready channel carrying one position sample and its first flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_in_if;
    import skf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_sample;

    modport source (output valid, output sample, output first_sample, input ready);
    modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

`default_nettype wire

### design/skf_out_if.sv
// ----------------------------------------------------------------------------
// skf_out_if: result channel
// Valid/ready channel carrying the filtered estimate and the gain used.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_out_if;
    import skf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] estimate;
    logic [GAIN_W-1:0]              gain;

    modport source (output valid, output estimate, output gain, input ready);
    modport sink   (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

### design/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core: one-dimensional Kalman filter
// Microcoded sequencer over a fixed-point datapath. Each sample word yields
// one result word with the updated estimate and the gain that was used.
//
//   Channel    Dir  Handshake           Contents
//   in_ch      in   valid / ready       sample (Q16.16), first_sample
//   out_ch     out  valid / ready       estimate (Q16.16), gain (Q1.16)
//   cfg        in   cfg_wr_en           cfg_index, cfg_data (R, Q)
//
// From acceptance, a regular sample runs the add-Q, denominator, bit-serial
// gain divider, innovation multiply, estimate update, covariance multiply,
// covariance update and emit steps; a first sample runs add-Q, first-sample
// and emit, then wait for the next word; one word is in work at a time.
// The output register holds a result while the next sample is taken in;
// the sequencer stalls in its emit step only if that register is still full.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    skf_in_if.sink                                   in_ch,
    skf_out_if.source                                out_ch,
    input  wire logic                                cfg_wr_en,
    input  wire logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [skf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import skf_pkg::*;

    logic [COV_W-1:0]               meas_noise_reg;
    logic [COV_W-1:0]               proc_noise_reg;
    logic [PC_W-1:0]                pc_reg, pc_next;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_est_reg;
    logic [GAIN_W-1:0]              out_gain_reg;

    skf_ucode_t                     uword;
    skf_status_t                    status;
    logic                           in_accept;
    logic                           can_emit;
    logic                           emit;
    logic signed [SAMPLE_WIDTH-1:0] est_cur;
    logic [GAIN_W-1:0]              gain_cur;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_noise_reg <= MEAS_NOISE_RESET;
            proc_noise_reg <= PROC_NOISE_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_MEAS_NOISE)
            begin
                meas_noise_reg <= cfg_data;
            end
            else if (cfg_index == REG_PROC_NOISE)
            begin
                proc_noise_reg <= cfg_data;
            end
        end
    end

    // Microcode fetch and handshake qualifiers.
    assign uword     = skf_ucode(pc_reg);
    assign in_ch.ready = (uword.op == OP_LOAD);
    assign in_accept = in_ch.valid && in_ch.ready;
    assign can_emit  = !out_valid_reg || out_ch.ready;
    assign emit      = (uword.op == OP_EMIT) && can_emit;

    // Step sequencing.
    always_comb
    begin
        pc_next = pc_reg + 1'b1;
        unique case (uword.jump)
            JC_NEXT:
            begin
                pc_next = pc_reg + 1'b1;
            end
            JC_GOTO:
            begin
                pc_next = uword.target;
            end
            JC_IF_FIRST:
            begin
                pc_next = status.first ? uword.target : pc_reg + 1'b1;
            end
            JC_DIV_LOOP:
            begin
                pc_next = status.div_last ? pc_reg + 1'b1 : uword.target;
            end
            JC_WAIT_IN:
            begin
                pc_next = in_accept ? pc_reg + 1'b1 : pc_reg;
            end
            JC_WAIT_OUT:
            begin
                pc_next = can_emit ? uword.target : pc_reg;
            end
            default:
            begin
                pc_next = PC_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Datapath.
    skf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (uword.op),
        .load_en    (in_accept),
        .sample_in  (in_ch.sample),
        .first_in   (in_ch.first_sample),
        .meas_noise (meas_noise_reg),
        .proc_noise (proc_noise_reg),
        .status     (status),
        .est_out    (est_cur),
        .gain_out   (gain_cur)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_est_reg  <= est_cur;
            out_gain_reg <= gain_cur;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.estimate = out_est_reg;
    assign out_ch.gain     = out_gain_reg;

`ifndef SYNTH
    // The program counter never leaves the program.
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_LAST)
        else $error("sequencer left the microcode program");

    // An accepted word always starts the update step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pc_reg == PC_ADDQ)
        else $error("accepted word did not start an update");

    // A delivered gain never exceeds one.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.gain <= ONE_Q16)
        else $error("gain above 1.0 on the output");

    // Input is never taken while a word is still in the datapath.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != PC_LOAD) |-> !in_ch.ready)
        else $error("input ready while an update is in progress");
`endif

endmodule

`default_nettype wire

### design/skf_datapath.sv
// ----------------------------------------------------------------------------
// skf_datapath: filter datapath
// Estimate and covariance state, a restoring divider for the gain and one
// shared multiplier, all driven by the operation field of the microcode word.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire skf_pkg::skf_op_t                       op,
    input  wire logic                                   load_en,
    input  wire logic signed [skf_pkg::SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic                                   first_in,
    input  wire logic [skf_pkg::COV_W-1:0]              meas_noise,
    input  wire logic [skf_pkg::COV_W-1:0]              proc_noise,
    output skf_pkg::skf_status_t                        status,
    output logic signed [skf_pkg::SAMPLE_WIDTH-1:0]     est_out,
    output logic [skf_pkg::GAIN_W-1:0]                  gain_out
);
    import skf_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           first_reg;
    logic signed [SAMPLE_WIDTH-1:0] est_reg, est_next;
    logic [COV_W-1:0]               cov_reg, cov_next;
    logic [COV_W-1:0]               p_reg, p_next;
    logic [DEN_W-1:0]               den_reg, den_next;
    logic                           den_zero_reg, den_zero_next;
    logic [REM_W-1:0]               rem_reg, rem_next;
    logic [GAIN_W-1:0]              q_reg, q_next;
    logic [DIV_CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;

    logic [COV_W:0]                 pq_sum;
    logic [COV_W-1:0]               p_sat;
    logic [DEN_W-1:0]               den_sum;
    logic                           rem_ge;
    logic [REM_W-1:0]               rem_sub;
    logic [GAIN_W-1:0]              gain_eff;
    logic signed [MUL_B_W-1:0]      innov;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       mul_p;

    // Saturating covariance prediction and the gain denominator.
    assign pq_sum  = {1'b0, cov_reg} + {1'b0, proc_noise};
    assign p_sat   = pq_sum[COV_W] ? '1 : pq_sum[COV_W-1:0];
    assign den_sum = {1'b0, p_reg} + {1'b0, meas_noise};

    // One restoring division step.
    assign rem_ge  = rem_reg >= {1'b0, den_reg};
    assign rem_sub = rem_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // A zero denominator gives a gain of zero.
    assign gain_eff = den_zero_reg ? '0 : q_reg;

    // Exact innovation, one bit wider than the sample.
    assign innov = MUL_B_W'(sample_reg) - MUL_B_W'(est_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        if (op == OP_MUL_COV)
        begin
            mul_a = $signed({1'b0, ONE_Q16 - q_reg});
            mul_b = $signed({{(MUL_B_W-COV_W){1'b0}}, p_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, gain_eff});
            mul_b = innov;
        end
    end

    assign mul_p = mul_a * mul_b;

    // Next-state logic per operation.
    always_comb
    begin
        est_next      = est_reg;
        cov_next      = cov_reg;
        p_next        = p_reg;
        den_next      = den_reg;
        den_zero_next = den_zero_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        unique case (op)
            OP_ADD_Q:
            begin
                p_next = p_sat;
            end
            OP_DEN:
            begin
                den_next      = den_sum;
                den_zero_next = (den_sum == '0);
                rem_next      = {2'b00, p_reg};
                q_next        = '0;
                cnt_next      = '0;
            end
            OP_DIV:
            begin
                rem_next = {rem_sub[REM_W-2:0], 1'b0};
                q_next   = {q_reg[GAIN_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            OP_MUL_INNOV:
            begin
                prod_next = mul_p;
                q_next    = gain_eff;
            end
            OP_UPD_EST:
            begin
                est_next = est_reg + prod_reg[FRAC_W +: SAMPLE_WIDTH];
            end
            OP_MUL_COV:
            begin
                prod_next = mul_p;
            end
            OP_UPD_COV:
            begin
                cov_next = prod_reg[FRAC_W +: COV_W];
            end
            OP_FIRST:
            begin
                est_next = sample_reg;
                cov_next = COV_INIT;
                q_next   = '0;
            end
            OP_LOAD, OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Filter state with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            cov_reg <= COV_INIT;
        end
        else
        begin
            est_reg <= est_next;
            cov_reg <= cov_next;
        end
    end

    // Working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sample_reg <= sample_in;
            first_reg  <= first_in;
        end
        p_reg        <= p_next;
        den_reg      <= den_next;
        den_zero_reg <= den_zero_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
    end

    assign status.first    = first_reg;
    assign status.div_last = (cnt_reg == DIV_LAST);
    assign est_out         = est_reg;
    assign gain_out        = q_reg;

endmodule

`default_nettype wire
